[rtl/serial_axis_frame_parser_top_macros.svh]
// assertion macros for the parser rtl, included by safp_ctrl
`ifndef SERIAL_AXIS_FRAME_PARSER_TOP_MACROS_SVH
`define SERIAL_AXIS_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define SAFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("safp assertion failed");
// checked at every edge, reset included
`define SAFP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("safp assertion failed");
`else
`define SAFP_ASSERT(lbl, prop)
`define SAFP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/safp_pkg.sv]
package safp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned SumW     = 14;
  localparam int unsigned ChkW     = 15;
  localparam int unsigned HiShift  = 7;
  localparam int unsigned AxisIdxW = 4;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [ByteW-1:0] HeaderRst = 8'd150;
  localparam logic [ByteW-1:0] FooterRst = 8'd141;
  localparam logic [WordW-1:0] InOffRst  = 16'd8192;
  localparam logic [WordW-1:0] OutOffRst = 16'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeader = 2'd0,
    CfgFooter = 2'd1,
    CfgInOff  = 2'd2,
    CfgOutOff = 2'd3
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic                sum_load;
    logic                sum_add;
    logic                hi_load;
    logic                mem_we;
    logic                chk_lo;
    logic                chk_hi;
    logic                rd_en;
    logic                out_load;
    logic                out_last;
    logic [AxisIdxW-1:0] addr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic header_match;
    logic frame_good;
    logic out_free;
  } status_t;

endpackage

[rtl/serial_axis_frame_parser_top.sv]
// a good frame-closing footer byte starts the read-out: per channel a frame store read,
//   then an output register load, which waits while the previous beat is held and not taken
// throughput: 1 byte per cycle while parsing; no input is taken while a good frame emits
// reset: rst_ni async active low; parser waits for a header, config back to defaults,
//   frame store contents left undefined
module serial_axis_frame_parser_top #(
  parameter int unsigned CHANNELS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [safp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [safp_pkg::WordW-1:0]    cfg_data_i,
  // received byte beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [safp_pkg::ByteW-1:0]    rx_byte_i,
  // axis value beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [safp_pkg::AxisIdxW-1:0] axis_index_o,
  output logic [safp_pkg::WordW-1:0]    axis_value_o,
  output logic                          last_axis_o
);

  // command and status between sequencer and datapath
  safp_pkg::cmd_t    cmd;
  safp_pkg::status_t status;

  // sequencer: frame phase, data byte count and channel read-out count
  safp_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: config, running sum, checksum, frame store, output register
  // the output register lets the parser take new bytes while the last
  // result beat still waits downstream
  safp_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .axis_index_o (axis_index_o),
    .axis_value_o (axis_value_o),
    .last_axis_o  (last_axis_o)
  );

endmodule

[rtl/safp_datapath.sv]
module safp_datapath #(
  parameter int unsigned CHANNELS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [safp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [safp_pkg::WordW-1:0]          cfg_data_i,
  input  logic [safp_pkg::ByteW-1:0]          rx_byte_i,
  input  safp_pkg::cmd_t                      cmd_i,
  output safp_pkg::status_t                   status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [safp_pkg::AxisIdxW-1:0]       axis_index_o,
  output logic [safp_pkg::WordW-1:0]          axis_value_o,
  output logic                                last_axis_o
);

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [safp_pkg::ByteW-1:0] header_q, footer_q;
  logic [safp_pkg::WordW-1:0] in_off_q, out_off_q;

  logic [safp_pkg::SumW-1:0]  sum_q;
  logic [safp_pkg::ByteW-1:0] hi_q;
  logic [safp_pkg::ByteW-1:0] chk_lo_q;
  logic [safp_pkg::ChkW-1:0]  chk_q;

  // one decoded raw value per channel
  logic [safp_pkg::WordW-1:0] mem_q [CHANNELS];
  logic [safp_pkg::WordW-1:0] rdata_q;
  logic [safp_pkg::WordW-1:0] raw_d;
  logic [safp_pkg::WordW-1:0] value_d;
  logic [ChW-1:0]             addr;

  logic                                out_valid_q;
  logic [safp_pkg::AxisIdxW-1:0]       out_idx_q;
  logic [safp_pkg::WordW-1:0]          out_val_q;
  logic                                out_last_q;

  assign addr    = cmd_i.addr[ChW-1:0];
  assign raw_d   = {1'b0, hi_q, {safp_pkg::HiShift{1'b0}}} +
                   {{(safp_pkg::WordW-safp_pkg::ByteW){1'b0}}, rx_byte_i};
  assign value_d = rdata_q - in_off_q + out_off_q;

  assign status_o.header_match = (rx_byte_i == header_q);
  assign status_o.frame_good   = (rx_byte_i == footer_q) && (chk_q == {1'b0, sum_q});
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= safp_pkg::HeaderRst;
      footer_q  <= safp_pkg::FooterRst;
      in_off_q  <= safp_pkg::InOffRst;
      out_off_q <= safp_pkg::OutOffRst;
    end else if (cfg_we_i) begin
      case (safp_pkg::cfg_idx_e'(cfg_index_i))
        safp_pkg::CfgHeader: header_q  <= cfg_data_i[safp_pkg::ByteW-1:0];
        safp_pkg::CfgFooter: footer_q  <= cfg_data_i[safp_pkg::ByteW-1:0];
        safp_pkg::CfgInOff:  in_off_q  <= cfg_data_i;
        safp_pkg::CfgOutOff: out_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sum and checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      chk_q    <= '0;
      hi_q     <= '0;
      chk_lo_q <= '0;
    end else begin
      if (cmd_i.sum_load) begin
        sum_q <= safp_pkg::SumW'(rx_byte_i);
      end else if (cmd_i.sum_add) begin
        sum_q <= sum_q + safp_pkg::SumW'(rx_byte_i);
      end
      if (cmd_i.hi_load) begin
        hi_q <= rx_byte_i;
      end
      if (cmd_i.chk_lo) begin
        chk_lo_q <= rx_byte_i;
      end
      if (cmd_i.chk_hi) begin
        chk_q <= {rx_byte_i, {safp_pkg::HiShift{1'b0}}} |
                 safp_pkg::ChkW'(chk_lo_q);
      end
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[addr] <= raw_d;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= cmd_i.addr;
      out_val_q  <= value_d;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign axis_index_o = out_idx_q;
  assign axis_value_o = out_val_q;
  assign last_axis_o  = out_last_q;

endmodule

[rtl/safp_ctrl.sv]
`include "serial_axis_frame_parser_top_macros.svh"

module safp_ctrl #(
  parameter int unsigned CHANNELS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  safp_pkg::status_t status_i,
  output safp_pkg::cmd_t    cmd_o
);

  localparam int unsigned ChW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IdxW = ChW + 1;
  localparam logic [ChW-1:0]  LastCh  = ChW'(CHANNELS - 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(2 * CHANNELS - 1);

  typedef enum logic [2:0] {
    StWait,
    StData,
    StChkLo,
    StChkHi,
    StFoot,
    StRead,
    StOut
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;
  logic [ChW-1:0]  ch_q;
  logic            fire;

  assign in_ready_o = (state_q == StWait) || (state_q == StData) ||
                      (state_q == StChkLo) || (state_q == StChkHi) ||
                      (state_q == StFoot);
  assign fire = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StWait:  cmd_o.sum_load = fire && status_i.header_match;
      StData: begin
        cmd_o.sum_add = fire;
        cmd_o.hi_load = fire && !idx_q[0];
        cmd_o.mem_we  = fire && idx_q[0];
        cmd_o.addr    = safp_pkg::AxisIdxW'(idx_q[IdxW-1:1]);
      end
      StChkLo: cmd_o.chk_lo = fire;
      StChkHi: cmd_o.chk_hi = fire;
      StRead: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.addr  = safp_pkg::AxisIdxW'(ch_q);
      end
      StOut: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_last = (ch_q == LastCh);
        cmd_o.addr     = safp_pkg::AxisIdxW'(ch_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StWait;
      idx_q   <= '0;
      ch_q    <= '0;
    end else begin
      case (state_q)
        StWait: begin
          if (fire && status_i.header_match) begin
            idx_q   <= '0;
            state_q <= StData;
          end
        end
        StData: begin
          if (fire) begin
            if (idx_q == LastIdx) begin
              idx_q   <= '0;
              state_q <= StChkLo;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        StChkLo: if (fire) state_q <= StChkHi;
        StChkHi: if (fire) state_q <= StFoot;
        StFoot: begin
          if (fire) begin
            ch_q    <= '0;
            state_q <= status_i.frame_good ? StRead : StWait;
          end
        end
        StRead: state_q <= StOut;
        StOut: begin
          if (status_i.out_free) begin
            if (ch_q == LastCh) begin
              state_q <= StWait;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= StRead;
            end
          end
        end
        default: state_q <= StWait;
      endcase
    end
  end

  // no byte is taken while a frame is being emitted
  `SAFP_ASSERT(a_no_rx_while_emit, (state_q == StRead || state_q == StOut) |-> !in_ready_o)
  // store writes only on the second byte of a data pair
  `SAFP_ASSERT(a_we_on_lo_byte, cmd_o.mem_we |-> (state_q == StData && idx_q[0]))
  // a good footer starts emission from channel zero
  `SAFP_ASSERT(a_good_starts_emit, (state_q == StFoot && fire && status_i.frame_good) |=> (state_q == StRead && ch_q == '0))
  // last channel closes the frame
  `SAFP_ASSERT(a_last_closes, (cmd_o.out_load && cmd_o.out_last) |=> state_q == StWait)
  // only one store operation per cycle
  `SAFP_ASSERT_ALWAYS(a_store_port, !(cmd_o.mem_we && cmd_o.rd_en))

endmodule

[sim/testbench.sv]
module testbench;

  localparam int unsigned Chans        = 6;
  localparam int unsigned FrameData    = 2 * Chans;
  // each beat of a good footer follows a store read and an output register load
  localparam int unsigned SettleCycles = 2 * Chans + 4;
  localparam int unsigned DirRows      = 25;
  localparam int unsigned PhaseBytes   = 40;

  // parser phases of the predictor
  typedef enum logic [1:0] {
    PhWait,
    PhData,
    PhCheck,
    PhFoot
  } phase_e;

  // how the expected beats of a stimulus row are obtained
  typedef enum logic [1:0] {
    RowModel,  // from the predictor
    RowQuiet,  // no beat at all
    RowSame    // Chans beats, all with the typed value
  } row_kind_e;

  typedef struct packed {
    logic [safp_pkg::ByteW-1:0] rx;
    row_kind_e                  kind;
    logic [safp_pkg::WordW-1:0] value;
  } stim_row_t;

  typedef struct packed {
    logic [safp_pkg::AxisIdxW-1:0] idx;
    logic [safp_pkg::WordW-1:0]    val;
    logic                          last;
  } axis_beat_t;

  logic                          clk_i;
  logic                          rst_ni       = 1'b0;
  logic                          cfg_we_i     = 1'b0;
  logic [safp_pkg::CfgIdxW-1:0]  cfg_index_i  = safp_pkg::CfgHeader;
  logic [safp_pkg::WordW-1:0]    cfg_data_i   = '0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_ready_o;
  logic [safp_pkg::ByteW-1:0]    rx_byte_i    = '0;
  logic                          out_valid_o;
  logic                          out_ready_i  = 1'b0;
  logic [safp_pkg::AxisIdxW-1:0] axis_index_o;
  logic [safp_pkg::WordW-1:0]    axis_value_o;
  logic                          last_axis_o;

  serial_axis_frame_parser_top #(
    .CHANNELS(Chans)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .axis_index_o(axis_index_o),
    .axis_value_o(axis_value_o),
    .last_axis_o (last_axis_o)
  );

  // register copies kept by the predictor
  logic [safp_pkg::ByteW-1:0] model_header;
  logic [safp_pkg::ByteW-1:0] model_footer;
  logic [safp_pkg::WordW-1:0] model_in_off;
  logic [safp_pkg::WordW-1:0] model_out_off;

  // parser state of the predictor
  phase_e                     model_phase;
  logic [4:0]                 model_idx;
  logic [safp_pkg::ByteW-1:0] model_store [FrameData];
  logic [safp_pkg::WordW-1:0] model_sum;
  logic [safp_pkg::WordW-1:0] model_check;

  axis_beat_t frame_beats[$];         // beats caused by the last byte
  axis_beat_t pending_axis_beats[$];  // beats still to come from the dut
  axis_beat_t want_beat;

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned bytes_sent;
  int unsigned frames_good;
  int unsigned frames_dropped;
  int unsigned beats_checked;
  int unsigned mismatches;

  // directed rows: noise while waiting, an all-zero frame whose first checksum
  // byte has bit 7 set, then a frame start holding the header value as data
  stim_row_t directed_rows [DirRows] = '{
    '{8'h00, RowQuiet, 16'h0000},
    '{8'hff, RowQuiet, 16'h0000},
    '{8'd150, RowQuiet, 16'h0000},
    '{8'h00, RowQuiet, 16'h0000}, '{8'h00, RowQuiet, 16'h0000},
    '{8'h00, RowQuiet, 16'h0000}, '{8'h00, RowQuiet, 16'h0000},
    '{8'h00, RowQuiet, 16'h0000}, '{8'h00, RowQuiet, 16'h0000},
    '{8'h00, RowQuiet, 16'h0000}, '{8'h00, RowQuiet, 16'h0000},
    '{8'h00, RowQuiet, 16'h0000}, '{8'h00, RowQuiet, 16'h0000},
    '{8'h00, RowQuiet, 16'h0000}, '{8'h00, RowQuiet, 16'h0000},
    // 150 | 1<<7 is still 150, the header-only sum
    '{8'd150, RowQuiet, 16'h0000},
    '{8'h01, RowQuiet, 16'h0000},
    // zero data: 0 - 8192 + 1024 wraps to 0xe400
    '{8'd141, RowSame, 16'he400},
    '{8'd150, RowQuiet, 16'h0000},
    '{8'd150, RowModel, 16'h0000},
    '{8'hff, RowModel, 16'h0000},
    '{8'h00, RowModel, 16'h0000},
    '{8'd150, RowModel, 16'h0000},
    '{8'h7f, RowModel, 16'h0000},
    '{8'h80, RowModel, 16'h0000}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop in case the dut hangs
  initial begin
    #(12 * 400000);
    $display("Mismatches found");
    $finish;
  end

  // predictor: advance the parser by one byte, fill frame_beats
  function automatic void parse_rx_byte(input logic [safp_pkg::ByteW-1:0] b);
    logic [safp_pkg::WordW-1:0] val;
    frame_beats.delete();
    case (model_phase)
      PhWait: begin
        // anything but the header is dropped here
        if (b == model_header) begin
          model_sum   = 16'(b);
          model_idx   = '0;
          model_phase = PhData;
        end
      end
      PhData: begin
        model_store[model_idx] = b;
        model_sum = model_sum + 16'(b);
        model_idx = model_idx + 5'd1;
        if (model_idx >= 5'(FrameData)) begin
          model_idx   = '0;
          model_check = '0;
          model_phase = PhCheck;
        end
      end
      PhCheck: begin
        // plain or of both bytes, so bit 7 of the first overlaps the second
        if (model_idx == 5'd0) begin
          model_check = model_check | 16'(b);
          model_idx   = 5'd1;
        end else begin
          model_check = model_check | (16'(b) << safp_pkg::HiShift);
          model_idx   = '0;
          model_phase = PhFoot;
        end
      end
      default: begin
        if (b == model_footer && model_check == (model_sum & 16'h3fff)) begin
          for (int c = 0; c < Chans; c++) begin
            val = (16'(model_store[2*c]) << safp_pkg::HiShift) + 16'(model_store[2*c+1])
                  - model_in_off + model_out_off;
            frame_beats.push_back('{safp_pkg::AxisIdxW'(c), val, c == Chans - 1});
          end
          frames_good++;
        end else begin
          frames_dropped++;
        end
        model_idx   = '0;
        model_phase = PhWait;
      end
    endcase
  endfunction

  // one byte beat; valid is left high on return so the next byte can follow
  task automatic send_byte(input logic [safp_pkg::ByteW-1:0] b, input row_kind_e kind,
                           input logic [safp_pkg::WordW-1:0] value);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    parse_rx_byte(b);
    case (kind)
      RowModel: foreach (frame_beats[i]) pending_axis_beats.push_back(frame_beats[i]);
      RowSame: begin
        for (int c = 0; c < Chans; c++)
          pending_axis_beats.push_back('{safp_pkg::AxisIdxW'(c), value, c == Chans - 1});
      end
      default: ;
    endcase
    bytes_sent++;
  endtask

  // stop sending and let every expected beat drain, plus the settle window
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_axis_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // writes all four registers; upper data bits of byte registers are junk
  task automatic set_config(input logic [safp_pkg::ByteW-1:0] h,
                            input logic [safp_pkg::ByteW-1:0] f,
                            input logic [safp_pkg::WordW-1:0] io,
                            input logic [safp_pkg::WordW-1:0] oo);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= safp_pkg::CfgHeader;
    cfg_data_i  <= {8'($urandom), h};
    @(posedge clk_i);
    cfg_index_i <= safp_pkg::CfgFooter;
    cfg_data_i  <= {8'($urandom), f};
    @(posedge clk_i);
    cfg_index_i <= safp_pkg::CfgInOff;
    cfg_data_i  <= io;
    @(posedge clk_i);
    cfg_index_i <= safp_pkg::CfgOutOff;
    cfg_data_i  <= oo;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    model_header  = h;
    model_footer  = f;
    model_in_off  = io;
    model_out_off = oo;
  endtask

  // mostly whole frames with random data, some corrupted, some loose noise
  task automatic send_random_unit();
    int unsigned                r;
    int unsigned                n;
    logic [safp_pkg::ByteW-1:0] d;
    logic [safp_pkg::ByteW-1:0] lo;
    logic [safp_pkg::ByteW-1:0] hi;
    logic [safp_pkg::ByteW-1:0] foot;
    logic [safp_pkg::WordW-1:0] sum;
    r = $urandom_range(99);
    if (r < 15) begin
      n = $urandom_range(3, 1);
      repeat (n) send_byte(8'($urandom), RowModel, '0);
    end else begin
      sum = 16'(model_header);
      send_byte(model_header, RowModel, '0);
      for (int k = 0; k < FrameData; k++) begin
        case ($urandom_range(7))
          0:       d = 8'h00;
          1:       d = 8'hff;
          default: d = 8'($urandom);
        endcase
        sum = sum + 16'(d);
        send_byte(d, RowModel, '0);
      end
      lo = {1'b0, sum[6:0]};
      hi = {1'b0, sum[13:7]};
      // bit 7 of the low byte may duplicate bit 0 of the high byte
      if (hi[0] && $urandom_range(1) == 1) lo[7] = 1'b1;
      foot = model_footer;
      r = $urandom_range(99);
      if (r < 10) begin
        foot = model_footer ^ 8'($urandom_range(255, 1));
      end else if (r < 20) begin
        hi = hi ^ (8'h01 << $urandom_range(7, 1));
      end
      send_byte(lo, RowModel, '0);
      send_byte(hi, RowModel, '0);
      send_byte(foot, RowModel, '0);
    end
  endtask

  // receiver: check the beat taken at this edge, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_axis_beats.size() == 0) begin
        $error("unexpected axis beat: index %0d value %0d", axis_index_o, axis_value_o);
        mismatches++;
      end else begin
        want_beat = pending_axis_beats.pop_front();
        if (axis_index_o !== want_beat.idx) begin
          $error("axis_index: expected %0d, got %0d", want_beat.idx, axis_index_o);
          mismatches++;
        end
        if (axis_value_o !== want_beat.val) begin
          $error("axis_value: expected %0d, got %0d", want_beat.val, axis_value_o);
          mismatches++;
        end
        if (last_axis_o !== want_beat.last) begin
          $error("last_axis: expected %0d, got %0d", want_beat.last, last_axis_o);
          mismatches++;
        end
        beats_checked++;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    int unsigned phase_start;
    bit          paused;

    // predictor starts from the reset state
    model_header   = safp_pkg::HeaderRst;
    model_footer   = safp_pkg::FooterRst;
    model_in_off   = safp_pkg::InOffRst;
    model_out_off  = safp_pkg::OutOffRst;
    model_phase    = PhWait;
    model_idx      = '0;
    model_sum      = '0;
    model_check    = '0;
    bytes_sent     = 0;
    frames_good    = 0;
    frames_dropped = 0;
    beats_checked  = 0;
    mismatches     = 0;
    send_idle      = 32;
    recv_idle      = 78;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with the reset register values
    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].kind, directed_rows[i].value);

    // random part: reset values, two extreme settings, one random setting
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        drain_results();
        case (ph)
          1: begin
            set_config(8'h00, 8'hff, 16'h0000, 16'hffff);
            send_idle = 78;
            recv_idle = 32;
          end
          2: begin
            // no idling on either side from here on
            set_config(8'hff, 8'h00, 16'hffff, 16'h0000);
            send_idle = 0;
            recv_idle = 0;
          end
          default: begin
            set_config(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
            send_idle = 0;
            recv_idle = 0;
          end
        endcase
      end
      phase_start = bytes_sent;
      paused      = 1'b0;
      while (bytes_sent - phase_start < PhaseBytes) begin
        send_random_unit();
        // sender holds off mid-phase until the output side is empty
        if (!paused && bytes_sent - phase_start >= 25) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();

    $display("run covered %0d received bytes: %0d frames accepted, %0d dropped",
             bytes_sent, frames_good, frames_dropped);
    $display("%0d axis beats compared over four register settings", beats_checked);
    if (mismatches == 0 && pending_axis_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
